@@ hdl/tgc_pkg.sv @@
`default_nettype none

package tgc_pkg;

	// timestamp width used for all press-time arithmetic
	localparam int TIME_BITS = 32;
	// width of the hold-time compares (wide enough for the 20-bit recal limit)
	localparam int CMP_W = (TIME_BITS > 20) ? TIME_BITS : 20;

	localparam int COUNT_W = 16;
	localparam int CFG_W   = 20;

	// result queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// reset values of the configuration registers
	localparam logic [14:0] INIT_THR_RST = 15'd35;
	localparam logic [7:0]  MARGIN_RST   = 8'd5;
	localparam logic [15:0] DBL_RST      = 16'd500;
	localparam logic [15:0] SHORT_RST    = 16'd1000;
	localparam logic [15:0] LONG_RST     = 16'd2000;
	localparam logic [19:0] RECAL_RST    = 20'd20000;

	// x/5 = (x * QUOT_MUL) >> QUOT_SHIFT, exact for x up to 32768
	localparam logic [15:0] QUOT_MUL   = 16'd52429;
	localparam int          QUOT_SHIFT = 18;

	typedef enum logic [2:0] {
		EV_TOUCH  = 3'd0,
		EV_LONG   = 3'd1,
		EV_SHORT  = 3'd2,
		EV_DOUBLE = 3'd3,
		EV_THRESH = 3'd4
	} tgc_event_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_FIRST  = 2'd1,
		PH_DOUBLE = 2'd2
	} tgc_phase_t;

	typedef enum logic [2:0] {
		CFG_INIT_THR = 3'd0,
		CFG_MARGIN   = 3'd1,
		CFG_DBL      = 3'd2,
		CFG_SHORT    = 3'd3,
		CFG_LONG     = 3'd4,
		CFG_RECAL    = 3'd5
	} tgc_cfg_idx_t;

	// the one or two results of one input item
	typedef struct packed {
		logic                      two;
		tgc_event_t                ev0;
		tgc_event_t                ev1;
		logic signed [COUNT_W-1:0] count;
		logic signed [COUNT_W-1:0] thr;
	} tgc_bundle_t;

endpackage

`default_nettype wire

@@ hdl/tgc_front.sv @@
`default_nettype none

module tgc_front
	import tgc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,
	input  wire logic        s_tuser,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire logic        q_full,
	output logic             q_push,
	output tgc_bundle_t      q_entry
);

	logic [7:0]  margin_q;
	logic [15:0] dbl_q;
	logic [15:0] short_q;
	logic [15:0] long_q;
	logic [19:0] recal_q;

	logic                      touched_q;
	tgc_phase_t                phase_q;
	logic [TIME_BITS-1:0]      press_q;
	logic signed [COUNT_W-1:0] thr_q;
	logic signed [COUNT_W-1:0] last_cnt_q;

	logic                      op;
	logic signed [COUNT_W-1:0] cnt;
	logic signed [COUNT_W-1:0] req;
	logic [TIME_BITS-1:0]      now;
	logic signed [17:0]        cnt_ext;
	logic signed [17:0]        thr_ext;
	logic signed [17:0]        rel_lim;
	logic                      cur;
	logic                      rise;
	logic [TIME_BITS-1:0]      dt_first;
	logic [TIME_BITS-1:0]      dt;
	logic [CMP_W-1:0]          dt_c;
	logic [16:0]               abs_cnt;
	logic [32:0]               prod;
	logic signed [17:0]        quot;
	logic signed [17:0]        recal_sum;
	logic signed [COUNT_W-1:0] recal_thr;
	tgc_phase_t                phase_n;
	logic [TIME_BITS-1:0]      press_n;
	logic signed [COUNT_W-1:0] thr_n;
	logic [1:0]                n_res;
	tgc_event_t                ev0;
	tgc_event_t                ev1;
	logic                      accept;

	assign op  = s_tuser;
	assign cnt = s_tdata[15:0];
	assign now = s_tdata[16 +: TIME_BITS];
	assign req = s_tdata[63:48];

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	assign cnt_ext = 18'(cnt);
	assign thr_ext = 18'(thr_q);
	assign rel_lim = thr_ext - $signed({10'd0, margin_q});

	// count + count/5, saturated to 16 bits
	assign abs_cnt   = cnt[15] ? 17'(-cnt_ext) : 17'(cnt_ext);
	assign prod      = 33'(abs_cnt) * 33'(QUOT_MUL);
	assign quot      = cnt[15] ? -$signed({3'd0, prod[32:QUOT_SHIFT]})
	                           :  $signed({3'd0, prod[32:QUOT_SHIFT]});
	assign recal_sum = cnt_ext + quot;

	always_comb begin
		if (recal_sum > 18'sd32767) begin
			recal_thr = 16'sh7fff;
		end else if (recal_sum < -18'sd32768) begin
			recal_thr = 16'sh8000;
		end else begin
			recal_thr = recal_sum[15:0];
		end
	end

	assign dt_first = now - press_q;

	always_comb begin
		cur = touched_q;
		if (cnt_ext > thr_ext) begin
			cur = 1'b1;
		end
		if (cnt_ext < rel_lim) begin
			cur = 1'b0;
		end
		rise    = cur && !touched_q;
		phase_n = phase_q;
		press_n = press_q;
		thr_n   = thr_q;
		n_res   = 2'd0;
		ev0     = EV_TOUCH;
		ev1     = EV_TOUCH;
		dt      = '0;
		dt_c    = '0;

		if (op) begin
			if (req > 16'sd0) begin
				thr_n = req;
			end
			ev0   = EV_THRESH;
			n_res = 2'd1;
		end else begin
			if (rise) begin
				if (phase_q == PH_IDLE) begin
					press_n = now;
					phase_n = PH_FIRST;
					ev0     = EV_TOUCH;
					n_res   = 2'd1;
				end else if (phase_q == PH_FIRST) begin
					if (CMP_W'(dt_first) < CMP_W'(dbl_q)) begin
						phase_n = PH_DOUBLE;
					end
				end
			end
			dt   = now - press_n;
			dt_c = CMP_W'(dt);

			if (phase_n == PH_FIRST && cur && dt_c > CMP_W'(long_q)) begin
				if (n_res == 2'd0) ev0 = EV_LONG; else ev1 = EV_LONG;
				n_res   = n_res + 2'd1;
				phase_n = PH_IDLE;
			end
			if (phase_n == PH_FIRST && !cur && dt_c > CMP_W'(short_q)) begin
				if (n_res == 2'd0) ev0 = EV_SHORT; else ev1 = EV_SHORT;
				n_res   = n_res + 2'd1;
				phase_n = PH_IDLE;
			end
			if (phase_n == PH_DOUBLE) begin
				if (n_res == 2'd0) ev0 = EV_DOUBLE; else ev1 = EV_DOUBLE;
				n_res   = n_res + 2'd1;
				phase_n = PH_IDLE;
			end
			if (phase_n == PH_IDLE && cur && dt_c > CMP_W'(recal_q) && n_res != 2'd2) begin
				if (n_res == 2'd0) ev0 = EV_THRESH; else ev1 = EV_THRESH;
				n_res = n_res + 2'd1;
				thr_n = recal_thr;
			end
		end
	end

	assign q_push        = accept && (n_res != 2'd0);
	assign q_entry.two   = (n_res == 2'd2);
	assign q_entry.ev0   = ev0;
	assign q_entry.ev1   = ev1;
	assign q_entry.count = op ? last_cnt_q : cnt;
	assign q_entry.thr   = thr_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q   <= MARGIN_RST;
			dbl_q      <= DBL_RST;
			short_q    <= SHORT_RST;
			long_q     <= LONG_RST;
			recal_q    <= RECAL_RST;
			touched_q  <= 1'b0;
			phase_q    <= PH_IDLE;
			press_q    <= '0;
			thr_q      <= $signed({1'b0, INIT_THR_RST});
			last_cnt_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INIT_THR: thr_q    <= $signed({1'b0, cfg_data[14:0]});
				CFG_MARGIN:   margin_q <= cfg_data[7:0];
				CFG_DBL:      dbl_q    <= cfg_data[15:0];
				CFG_SHORT:    short_q  <= cfg_data[15:0];
				CFG_LONG:     long_q   <= cfg_data[15:0];
				CFG_RECAL:    recal_q  <= cfg_data;
				default: ;
			endcase
		end else if (accept) begin
			thr_q <= thr_n;
			if (!op) begin
				touched_q  <= cur;
				phase_q    <= phase_n;
				press_q    <= press_n;
				last_cnt_q <= cnt;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/tgc_fifo.sv @@
`default_nettype none

module tgc_fifo
	import tgc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire tgc_bundle_t wr_entry,
	output logic       full,
	input  wire logic  pop,
	output tgc_bundle_t rd_entry,
	output logic       empty
);

	tgc_bundle_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     fill_q;

	assign full     = (fill_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty    = (fill_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/tgc_back.sv @@
`default_nettype none

module tgc_back
	import tgc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire tgc_bundle_t q_entry,
	output logic             q_pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,
	output logic [2:0]       m_tuser,
	output logic             m_tlast
);

	tgc_bundle_t cur_q;
	logic        valid_q;
	logic        idx_q;
	logic        last_now;

	assign last_now = !cur_q.two || idx_q;
	assign q_pop    = !q_empty && (!valid_q || (m_tready && last_now));

	assign m_tvalid = valid_q;
	assign m_tlast  = last_now;
	assign m_tuser  = idx_q ? cur_q.ev1 : cur_q.ev0;
	assign m_tdata  = {cur_q.thr, cur_q.count};

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
			idx_q   <= 1'b0;
		end else if (valid_q && m_tready) begin
			if (last_now) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/touch_gesture_classifier.sv @@
// A result is written to the result queue and then to the output register before it
// is valid. Throughput: one item per cycle; a two-result item holds the output for
// both of its results, absorbed by the four-entry result queue, which stalls the
// input only when full.
// Reset: asynchronous, active low; clears touch and gesture state and the
// queue, and loads the configuration defaults (threshold 35).
`default_nettype none

module touch_gesture_classifier
	import tgc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // sample_count[15:0], now_ms[47:16], new_threshold[63:48]
	input  wire logic        s_tuser,   // operation: 0 sample, 1 set threshold
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // count_value[15:0], threshold_value[31:16]
	output logic [2:0]       m_tuser,   // event_res
	output logic             m_tlast,   // final result of the item
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [19:0] cfg_data
);

	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	tgc_bundle_t q_wr;
	tgc_bundle_t q_rd;

	// Front: hysteresis, gesture tracking and threshold update, one item a cycle while the queue is not full.
	// Each item leaves zero, one or two results, bundled into one queue entry.
	tgc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_wr)
	);

	// Queue: decouples the tracker from a stalled downstream.
	tgc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (q_rd),
		.empty    (q_empty)
	);

	// Back: output register; unpack a bundle into one or two result items.
	tgc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_entry  (q_rd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

@@ hdl/tgc_checker.sv @@
`default_nettype none

module tgc_checker
	import tgc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("stalled result changed");

	// only a long or double press can be followed by a second result
	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == EV_LONG || m_tuser == EV_DOUBLE)
		else $error("unexpected event before a second result");

	// the second result is a threshold report, right behind, same count and threshold
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && m_tlast && m_tuser == EV_THRESH && m_tdata == $past(m_tdata))
		else $error("second result of an item malformed");

endmodule

bind touch_gesture_classifier tgc_checker u_chk (.*);

`default_nettype wire
